[rtl/mfd_pkg.sv]
// Shared types and constants for the motor feedback multi-turn decoder.
// No dependencies; every other file in rtl imports this package.
package mfd_pkg;

  localparam int ByteW = 8;
  localparam int WordW = 16;
  localparam int WideW = WordW + 1;
  localparam int ContW = 32;
  localparam int TurnBits = 13;
  localparam int ContExtW = ContW - WordW - TurnBits;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic signed [WideW-1:0] LAP_JUMP = 17'sd4000;
  localparam logic signed [WideW-1:0] LAP_LIMIT = 17'sd32500;
  localparam logic [WordW-1:0] TIMEOUT_RESET = 16'd50;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] byte_0;
    logic [ByteW-1:0] byte_1;
    logic [ByteW-1:0] byte_2;
    logic [ByteW-1:0] byte_3;
    logic [ByteW-1:0] byte_4;
    logic [ByteW-1:0] byte_5;
    logic [ByteW-1:0] byte_6;
  } mfd_req_t;

  typedef struct packed {
    logic signed [WordW-1:0] angle;
    logic signed [WordW-1:0] speed;
    logic signed [WordW-1:0] current;
    logic [ByteW-1:0]        temperature;
    logic signed [WordW-1:0] laps;
    logic signed [ContW-1:0] continuous_angle;
    logic                    laps_wrapped;
    logic                    online;
  } mfd_res_t;

endpackage

[rtl/mfd_in_stage.sv]
// Input register stage: captures one request and holds it until the
// tracking logic and output register can take it. Depends on mfd_pkg.
module mfd_in_stage import mfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mfd_req_t req_i,
  input  logic     advance,
  output logic     valid_o,
  output mfd_req_t req_o
);

  logic     valid_r, valid_nxt;
  mfd_req_t req_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= req_i;
    end
  end

  assign valid_o = valid_r;
  assign req_o = req_r;

endmodule

[rtl/mfd_track.sv]
// Decode, lap tracking and offline countdown: holds the decoder state and
// forms the result for the request in the input register. Depends on mfd_pkg.
module mfd_track import mfd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  mfd_req_t         req_i,
  input  logic [WordW-1:0] timeout_i,
  output mfd_res_t         res_o
);

  logic signed [WordW-1:0] prev_angle_r, prev_angle_nxt;
  logic signed [WordW-1:0] lap_r, lap_nxt;
  logic signed [WordW-1:0] speed_r, speed_nxt;
  logic signed [WordW-1:0] current_r, current_nxt;
  logic [ByteW-1:0]        temp_r, temp_nxt;
  logic [WordW-1:0]        countdown_r, countdown_nxt;

  logic signed [WordW-1:0] angle_in;
  logic signed [WideW-1:0] diff;
  logic signed [WideW-1:0] lap_step;
  logic                    wrap;

  always_comb begin
    angle_in = $signed({req_i.byte_0, req_i.byte_1});
    diff = $signed({angle_in[WordW-1], angle_in})
         - $signed({prev_angle_r[WordW-1], prev_angle_r});
    lap_step = $signed({lap_r[WordW-1], lap_r});
    priority if (diff < -LAP_JUMP) begin
      lap_step = lap_step + 17'sd1;
    end else if (diff > LAP_JUMP) begin
      lap_step = lap_step - 17'sd1;
    end
    wrap = (lap_step > LAP_LIMIT) || (lap_step < -LAP_LIMIT);

    prev_angle_nxt = prev_angle_r;
    lap_nxt = lap_r;
    speed_nxt = speed_r;
    current_nxt = current_r;
    temp_nxt = temp_r;
    countdown_nxt = countdown_r;
    if (req_i.kind == KIND_FRAME) begin
      prev_angle_nxt = angle_in;
      lap_nxt = wrap ? '0 : lap_step[WordW-1:0];
      speed_nxt = $signed({req_i.byte_2, req_i.byte_3});
      current_nxt = $signed({req_i.byte_4, req_i.byte_5});
      temp_nxt = req_i.byte_6;
      countdown_nxt = timeout_i;
    end else if (countdown_r != '0) begin
      countdown_nxt = countdown_r - 16'd1;
    end

    res_o.angle = prev_angle_nxt;
    res_o.speed = speed_nxt;
    res_o.current = current_nxt;
    res_o.temperature = temp_nxt;
    res_o.laps = lap_nxt;
    res_o.continuous_angle = $signed({{ContExtW{lap_nxt[WordW-1]}}, lap_nxt, {TurnBits{1'b0}}})
                           + $signed({{(ContW-WordW){prev_angle_nxt[WordW-1]}},
                                      prev_angle_nxt});
    res_o.laps_wrapped = (req_i.kind == KIND_FRAME) && wrap;
    res_o.online = countdown_nxt != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      lap_r <= '0;
      speed_r <= '0;
      current_r <= '0;
      temp_r <= '0;
      countdown_r <= '0;
    end else if (fire) begin
      prev_angle_r <= prev_angle_nxt;
      lap_r <= lap_nxt;
      speed_r <= speed_nxt;
      current_r <= current_nxt;
      temp_r <= temp_nxt;
      countdown_r <= countdown_nxt;
    end
  end

endmodule

[rtl/mfd_out_stage.sv]
// Result register: holds one finished result until the consumer takes it.
// Depends on mfd_pkg.
module mfd_out_stage import mfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  mfd_res_t res_i,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_ready,
  output mfd_res_t res_o
);

  logic     valid_r, valid_nxt;
  mfd_res_t res_r;

  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign res_o = res_r;

endmodule

[rtl/motor_feedback_multiturn_decoder_core.sv]
// Motor feedback multi-turn decoder, top level: input register, tracking
// logic, result register and the timeout register. Depends on mfd_pkg and
// mfd_in_stage, mfd_track, mfd_out_stage.
//
// Each request is a feedback frame or a time tick and yields exactly one
// result. A request is captured in the input register, the decode, lap
// count and countdown update are done on the way to the result register,
// and its result is held there until the consumer takes it. One request is
// accepted every cycle while results are taken; the lap state register
// closes its loop through combinational logic alone, so it sets no further
// limit. The timeout register resets to 50 and should only be written while
// no request is in flight.
module motor_feedback_multiturn_decoder_core import mfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [WordW-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [ByteW-1:0]        in_byte_0,
  input  logic [ByteW-1:0]        in_byte_1,
  input  logic [ByteW-1:0]        in_byte_2,
  input  logic [ByteW-1:0]        in_byte_3,
  input  logic [ByteW-1:0]        in_byte_4,
  input  logic [ByteW-1:0]        in_byte_5,
  input  logic [ByteW-1:0]        in_byte_6,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [WordW-1:0] out_angle,
  output logic signed [WordW-1:0] out_speed,
  output logic signed [WordW-1:0] out_current,
  output logic [ByteW-1:0]        out_temperature,
  output logic signed [WordW-1:0] out_laps,
  output logic signed [ContW-1:0] out_continuous_angle,
  output logic                    out_laps_wrapped,
  output logic                    out_online
);

  logic [WordW-1:0] timeout_r;
  mfd_req_t         req_in, req_s1;
  mfd_res_t         res_comb, res_out;
  logic             s1_valid, advance, fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  assign req_in = '{kind: in_kind, byte_0: in_byte_0, byte_1: in_byte_1,
                    byte_2: in_byte_2, byte_3: in_byte_3, byte_4: in_byte_4,
                    byte_5: in_byte_5, byte_6: in_byte_6};

  assign fire = s1_valid && advance;

  mfd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_i    (req_in),
    .advance  (advance),
    .valid_o  (s1_valid),
    .req_o    (req_s1)
  );

  mfd_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req_i     (req_s1),
    .timeout_i (timeout_r),
    .res_o     (res_comb)
  );

  mfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_i     (res_comb),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res_out)
  );

  assign out_angle = res_out.angle;
  assign out_speed = res_out.speed;
  assign out_current = res_out.current;
  assign out_temperature = res_out.temperature;
  assign out_laps = res_out.laps;
  assign out_continuous_angle = res_out.continuous_angle;
  assign out_laps_wrapped = res_out.laps_wrapped;
  assign out_online = res_out.online;

  a_laps_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_laps <= 16'sd32500) && (out_laps >= -16'sd32500))
    else $error("lap count out of range");

  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_laps_wrapped |-> out_laps == '0)
    else $error("wrap flag set with nonzero lap count");

  a_cont_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_continuous_angle ==
      $signed({{ContExtW{out_laps[WordW-1]}}, out_laps, {TurnBits{1'b0}}})
      + $signed({{(ContW-WordW){out_angle[WordW-1]}}, out_angle}))
    else $error("continuous angle mismatch");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && s1_valid)
    else $error("input stalled without a blocked result");

endmodule
